// ===== rtl/core/bra_pkg.sv =====
// bra_pkg: shared constants for the bitmap run allocator
// opcodes, status codes, word and field widths
// no dependencies
`timescale 1ns / 1ps

package bra_pkg;

	localparam int MAP_BITS_DEF = 1024;
	localparam int WORD_W       = 32;
	localparam int POS_W        = $clog2(WORD_W);
	localparam int RUN_W        = 12;
	localparam int IDX_FW       = 10;
	localparam int WANT_FW      = 11;
	localparam int BYTES_FW     = 8;
	localparam int BYTES_RESET  = 128;
	localparam int ACT_W        = 11;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_TEST  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_SCAN  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

endpackage

// ===== rtl/core/bra_cell.sv =====
// bra_cell: one bitmap word of the rotating word ring
// takes its neighbor's word on each shift, cleared by reset or clear_all
// depends on bra_pkg
`timescale 1ns / 1ps

module bra_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic                       clear,
	input  logic [bra_pkg::WORD_W-1:0] d,
	output logic [bra_pkg::WORD_W-1:0] q
);

	logic [bra_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (clear) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ===== rtl/core/bra_scan.sv =====
// bra_scan: free-run search over the word at the head of the ring
// carries the zero run length in from the previous word and out to the next
// depends on bra_pkg
`timescale 1ns / 1ps

module bra_scan #(
	parameter int CNT_W = 5,
	parameter int IDX_W = 12
) (
	input  logic [bra_pkg::WORD_W-1:0]  word,
	input  logic [CNT_W-1:0]            word_idx,
	input  logic [bra_pkg::ACT_W-1:0]   lim,
	input  logic [bra_pkg::RUN_W-1:0]   run_in,
	input  logic [bra_pkg::WANT_FW-1:0] want,
	output logic                        hit,
	output logic [bra_pkg::IDX_FW-1:0]  start,
	output logic [bra_pkg::RUN_W-1:0]   run_out
);

	logic [bra_pkg::RUN_W-1:0] run_len [bra_pkg::WORD_W];
	logic [bra_pkg::WORD_W-1:0] hits;
	logic [bra_pkg::POS_W-1:0] pos;
	logic [IDX_W-1:0] start_full;

	// run of zeros ending at each bit, and whether it is long enough inside the active range
	always_comb begin
		logic [bra_pkg::POS_W-1:0] last_one;
		logic seen;
		logic [bra_pkg::RUN_W:0] ext;
		logic [IDX_W-1:0] gidx;
		for (int j = 0; j < bra_pkg::WORD_W; j++) begin
			last_one = '0;
			seen = 1'b0;
			for (int k = 0; k < bra_pkg::WORD_W; k++) begin
				if (k <= j && word[k]) begin
					last_one = bra_pkg::POS_W'(k);
					seen = 1'b1;
				end
			end
			ext = {1'b0, run_in} + (bra_pkg::RUN_W + 1)'(j + 1);
			if (seen) begin
				run_len[j] = bra_pkg::RUN_W'(j) - bra_pkg::RUN_W'(last_one);
			end else begin
				run_len[j] = ext[bra_pkg::RUN_W] ? '1 : ext[bra_pkg::RUN_W-1:0];
			end
			gidx = IDX_W'({word_idx, bra_pkg::POS_W'(j)});
			hits[j] = (run_len[j] >= bra_pkg::RUN_W'(want)) && (gidx < IDX_W'(lim));
		end
	end

	// lowest hit wins
	always_comb begin
		pos = '0;
		for (int j = bra_pkg::WORD_W - 1; j >= 0; j--) begin
			if (hits[j]) begin
				pos = bra_pkg::POS_W'(j);
			end
		end
	end

	assign hit        = |hits;
	assign run_out    = run_len[bra_pkg::WORD_W-1];
	assign start_full = IDX_W'({word_idx, pos}) + IDX_W'(1) - IDX_W'(want);
	assign start      = start_full[bra_pkg::IDX_FW-1:0];

endmodule

// ===== rtl/core/bitmap_run_allocator_unit.sv =====
// bitmap_run_allocator_unit: first-fit allocation bitmap held in a ring of word cells
// instantiates bra_cell (one per 32-bit word) and bra_scan (head-of-ring search)
// depends on bra_pkg
//
// usage: items arrive on s_t* with the opcode in s_tuser; each item gives one
// transfer on m_t* with the status in m_tuser. bytes_in_use is written over
// cfg_valid/cfg_data (always ready); the user must write it only while the
// block is idle, as the block itself does not enforce it. clear_all zeroes
// every word at the accepting edge; its result is offered from the hold state
// once the output register is free. test, write and scan rotate the whole
// ring of NUM_WORDS words (32 for a 1024-bit map) once, one word per cycle
// past the scan cell at its head, then offer their result from the hold state.
// one item is worked on at a time: a new item is taken as soon as the last
// result sits in the output register, even if the receiver has not taken it yet.
// if the receiver stalls, the next result waits in the block and no further
// item is taken.
// reset clears the whole map and sets bytes_in_use to 128.
`timescale 1ns / 1ps

module bitmap_run_allocator_unit #(
	parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // bit_index[9:0], bit_value[10], run_length[21:11]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // start_index[9:0], bit_read[10]
	output logic [1:0]  m_tuser,  // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int NUM_WORDS = (MAP_BITS + bra_pkg::WORD_W - 1) / bra_pkg::WORD_W;
	localparam int CNT_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int IDX_W     = (CNT_W + bra_pkg::POS_W > 12) ? CNT_W + bra_pkg::POS_W : 12;
	localparam int CAP       = (MAP_BITS < 2040) ? MAP_BITS : 2040;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] op_q;
	logic [bra_pkg::IDX_FW-1:0] idx_q;
	logic val_q;
	logic [bra_pkg::WANT_FW-1:0] want_q;
	logic in_range_q;
	logic found_q;
	logic [bra_pkg::IDX_FW-1:0] start_q;
	logic read_q;
	logic [bra_pkg::RUN_W-1:0] run_q;
	logic m_tvalid_q;
	logic [1:0] m_status_q;
	logic [bra_pkg::IDX_FW-1:0] m_start_q;
	logic m_read_q;
	logic [bra_pkg::BYTES_FW-1:0] bytes_q;

	logic [bra_pkg::WORD_W-1:0] cell_q [NUM_WORDS];
	logic [bra_pkg::WORD_W-1:0] head;
	logic [bra_pkg::WORD_W-1:0] tail;
	logic accept;
	logic clear_all;
	logic [bra_pkg::ACT_W-1:0] act_bits;
	logic [bra_pkg::ACT_W-1:0] lim;
	logic at_word;
	logic touch;
	logic scan_en;
	logic last;
	logic hold_ok;
	logic scan_hit;
	logic [bra_pkg::IDX_FW-1:0] scan_start;
	logic [bra_pkg::RUN_W-1:0] scan_run;
	logic [1:0] hold_status;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign clear_all = accept && (s_tuser == bra_pkg::OP_CLEAR);
	assign cfg_ready = 1'b1;

	assign act_bits = {bytes_q, 3'b000};
	assign lim      = (act_bits > bra_pkg::ACT_W'(CAP)) ? bra_pkg::ACT_W'(CAP) : act_bits;

	assign head    = cell_q[0];
	assign at_word = IDX_W'(idx_q[bra_pkg::IDX_FW-1:bra_pkg::POS_W]) == IDX_W'(cnt_q);
	assign touch   = in_range_q && at_word;
	assign scan_en = (op_q == bra_pkg::OP_SCAN) && (want_q != '0) && !found_q;
	assign last    = (cnt_q == CNT_W'(NUM_WORDS - 1));
	assign hold_ok = !m_tvalid_q || m_tready;

	always_comb begin
		tail = head;
		if (op_q == bra_pkg::OP_WRITE && touch) begin
			tail[idx_q[bra_pkg::POS_W-1:0]] = val_q;
		end
	end

	always_comb begin
		case (op_q)
			bra_pkg::OP_CLEAR: hold_status = bra_pkg::ST_OK;
			bra_pkg::OP_TEST,
			bra_pkg::OP_WRITE: hold_status = in_range_q ? bra_pkg::ST_OK : bra_pkg::ST_RANGE;
			bra_pkg::OP_SCAN:  hold_status = found_q ? bra_pkg::ST_OK : bra_pkg::ST_NOT_FOUND;
			default:           hold_status = bra_pkg::ST_OK;
		endcase
	end

	for (genvar g = 0; g < NUM_WORDS; g++) begin : g_ring
		logic [bra_pkg::WORD_W-1:0] d_in;
		if (g == NUM_WORDS - 1) begin : g_tail
			assign d_in = tail;
		end else begin : g_mid
			assign d_in = cell_q[g+1];
		end
		bra_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (state_q == S_RUN),
			.clear  (clear_all),
			.d      (d_in),
			.q      (cell_q[g])
		);
	end

	bra_scan #(
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) u_scan (
		.word     (head),
		.word_idx (cnt_q),
		.lim      (lim),
		.run_in   (run_q),
		.want     (want_q),
		.hit      (scan_hit),
		.start    (scan_start),
		.run_out  (scan_run)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= bra_pkg::BYTES_FW'(bra_pkg::BYTES_RESET);
		end else if (cfg_valid && cfg_ready) begin
			bytes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			op_q       <= bra_pkg::OP_CLEAR;
			idx_q      <= '0;
			val_q      <= 1'b0;
			want_q     <= '0;
			in_range_q <= 1'b0;
			found_q    <= 1'b0;
			start_q    <= '0;
			read_q     <= 1'b0;
			run_q      <= '0;
			m_status_q <= bra_pkg::ST_OK;
			m_start_q  <= '0;
			m_read_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_HOLD) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= s_tuser;
						idx_q      <= s_tdata[9:0];
						val_q      <= s_tdata[10];
						want_q     <= s_tdata[21:11];
						in_range_q <= bra_pkg::ACT_W'(s_tdata[9:0]) < lim;
						cnt_q      <= '0;
						found_q    <= 1'b0;
						start_q    <= '0;
						read_q     <= 1'b0;
						run_q      <= '0;
						state_q    <= (s_tuser == bra_pkg::OP_CLEAR) ? S_HOLD : S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (op_q == bra_pkg::OP_TEST && touch) begin
						read_q <= head[idx_q[bra_pkg::POS_W-1:0]];
					end
					if (scan_en) begin
						run_q <= scan_run;
						if (scan_hit) begin
							found_q <= 1'b1;
							start_q <= scan_start;
						end
					end
					if (last) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (hold_ok) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= hold_status;
						m_start_q  <= start_q;
						m_read_q   <= read_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {5'b00000, m_read_q, m_start_q};

	// non-clear items rotate the full ring before the result is ready
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser != bra_pkg::OP_CLEAR) |-> ##(NUM_WORDS + 1) (state_q == S_HOLD))
		else $error("ring rotation length wrong");

	// results only leave the hold state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_HOLD))
		else $error("result without hold");

	// failed items carry a zero start index and a zero bit_read
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != bra_pkg::ST_OK) |-> (m_tdata[9:0] == '0 && !m_tdata[10]))
		else $error("nonzero payload on failed item");

	// word counter stays inside the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (IDX_W'(cnt_q) < IDX_W'(NUM_WORDS)))
		else $error("word counter out of ring");

	// a found run starts inside the active range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD && op_q == bra_pkg::OP_SCAN && found_q)
		|-> (bra_pkg::ACT_W'(start_q) < lim))
		else $error("run start outside active range");

endmodule

// ===== verif/bitmap_run_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// bitmap_run_allocator_unit_tb: self-checking bench for the first-fit bitmap run allocator
// streams opcodes under random bursts and stalls, predicts every result and checks it in order
// depends on bra_pkg and bitmap_run_allocator_unit

module bitmap_run_allocator_unit_tb;

	localparam int MAP_BITS    = 1024;
	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 48;
	localparam int PHASE_ITEMS = 172;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  idx;
		logic        val;
		logic [10:0] run;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] start;
		logic       rd;
	} alloc_rsp_t;

	class alloc_scoreboard;
		bit         map_bits[MAP_BITS];
		bit [7:0]   bytes_in_use;
		alloc_rsp_t due[$];
		int         errors;

		function new();
			foreach (map_bits[i])
				map_bits[i] = 1'b0;
			bytes_in_use = 8'd128;
			errors = 0;
		endfunction

		function int active_bits();
			int n;
			n = int'(bytes_in_use) * 8;
			return (n > MAP_BITS) ? MAP_BITS : n;
		endfunction

		function alloc_rsp_t predict_response(alloc_req_t r);
			alloc_rsp_t rsp;
			int lim;
			int count;
			bit found;
			rsp = '0;
			rsp.status = bra_pkg::ST_OK;
			lim = active_bits();
			count = 0;
			found = 1'b0;
			case (r.op)
				bra_pkg::OP_CLEAR: begin
					foreach (map_bits[i])
						map_bits[i] = 1'b0;
				end
				bra_pkg::OP_TEST: begin
					if (int'(r.idx) < lim)
						rsp.rd = map_bits[r.idx];
					else
						rsp.status = bra_pkg::ST_RANGE;
				end
				bra_pkg::OP_WRITE: begin
					if (int'(r.idx) < lim)
						map_bits[r.idx] = r.val;
					else
						rsp.status = bra_pkg::ST_RANGE;
				end
				default: begin
					if (r.run != 0) begin
						for (int i = 0; i < lim && !found; i++) begin
							if (map_bits[i])
								count = 0;
							else
								count++;
							if (count == int'(r.run)) begin
								found = 1'b1;
								rsp.start = 10'(i + 1 - count);
							end
						end
					end
					if (!found) begin
						rsp.status = bra_pkg::ST_NOT_FOUND;
						rsp.start = '0;
					end
				end
			endcase
			return rsp;
		endfunction

		function void note_request(alloc_req_t r);
			due.push_back(predict_response(r));
		endfunction

		function int pending();
			return due.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task check_response(alloc_rsp_t got);
			alloc_rsp_t want;
			if (due.size() == 0) begin
				report($sformatf("result with none due, status %0d start %0d read %0d",
					got.status, got.start, got.rd));
			end else begin
				want = due.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.start !== want.start)
					report($sformatf("start_index %0d, want %0d", got.start, want.start));
				if (got.rd !== want.rd)
					report($sformatf("bit_read %0d, want %0d", got.rd, want.rd));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // bit_index[9:0], bit_value[10], run_length[21:11]
	logic [1:0]  s_tuser;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // start_index[9:0], bit_read[10]
	logic [1:0]  m_tuser;   // status[1:0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	alloc_scoreboard sb = new();
	int burst_left = 0;
	int fill_cursor = 0;

	bitmap_run_allocator_unit #(
		.MAP_BITS(MAP_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// result side: stall pattern switches between free flow, coin flips and long holds
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_response({m_tuser, m_tdata[9:0], m_tdata[10]});
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 120);
			end
			left--;
			case (mode)
				0, 3: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	function automatic alloc_req_t mk(logic [1:0] op, int idx, bit val, int run);
		alloc_req_t r;
		r.op = op;
		r.idx = 10'(idx);
		r.val = val;
		r.run = 11'(run);
		return r;
	endfunction

	function automatic alloc_req_t rand_request();
		alloc_req_t r;
		int lim;
		int pick;
		lim = sb.active_bits();
		pick = $urandom_range(0, 99);
		r.op = (pick < 3) ? bra_pkg::OP_CLEAR : (pick < 45) ? bra_pkg::OP_WRITE :
			(pick < 65) ? bra_pkg::OP_TEST : bra_pkg::OP_SCAN;
		if (lim > 0 && $urandom_range(0, 9) < 8)
			r.idx = 10'($urandom_range(0, lim - 1));
		else
			r.idx = 10'($urandom_range(0, 1023));
		r.val = ($urandom_range(0, 99) < 65);
		pick = $urandom_range(0, 19);
		if (pick < 12)
			r.run = 11'($urandom_range(1, 8));
		else if (pick < 17)
			r.run = 11'($urandom_range(1, 64));
		else if (pick < 19)
			r.run = 11'($urandom_range(0, 2047));
		else
			r.run = 11'(lim + $urandom_range(0, 1) - (($urandom_range(0, 2) == 0) ? lim : 0));
		// grow clusters of set bits so scans see fragmented free space
		if (r.op == bra_pkg::OP_WRITE && lim > 0 && $urandom_range(0, 2) == 0) begin
			r.idx = 10'(fill_cursor % lim);
			r.val = 1'b1;
			fill_cursor += $urandom_range(1, 3);
		end
		return r;
	endfunction

	task automatic send_item(alloc_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, r.run, r.val, r.idx};
		s_tuser <= r.op;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(r);
	endtask

	task automatic idle_until_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_bytes_in_use(logic [7:0] v);
		idle_until_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.bytes_in_use = v;
	endtask

	initial begin
		logic [7:0] phase_bytes[9];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= bra_pkg::OP_CLEAR;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full map after reset: ends, zero run, runs longer than the range
		send_item(mk(bra_pkg::OP_TEST, 0, 1'b0, 0));
		send_item(mk(bra_pkg::OP_WRITE, 0, 1'b1, 0));
		send_item(mk(bra_pkg::OP_WRITE, 1023, 1'b1, 2047));
		send_item(mk(bra_pkg::OP_TEST, 1023, 1'b0, 0));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 0));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1022));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1023));
		send_item(mk(bra_pkg::OP_SCAN, 1023, 1'b1, 2047));
		send_item(mk(bra_pkg::OP_WRITE, 0, 1'b0, 0));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1023));
		send_item(mk(bra_pkg::OP_CLEAR, 1023, 1'b1, 2047));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1024));
		send_item(mk(bra_pkg::OP_TEST, 1023, 1'b0, 0));

		// one byte active: out of range, then a full map
		write_bytes_in_use(8'd1);
		send_item(mk(bra_pkg::OP_WRITE, 8, 1'b1, 0));
		send_item(mk(bra_pkg::OP_TEST, 8, 1'b0, 0));
		for (int i = 0; i < 8; i++)
			send_item(mk(bra_pkg::OP_WRITE, i, 1'b1, 0));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1));
		send_item(mk(bra_pkg::OP_TEST, 7, 1'b0, 0));

		// nothing active
		write_bytes_in_use(8'd0);
		send_item(mk(bra_pkg::OP_TEST, 0, 1'b0, 0));
		send_item(mk(bra_pkg::OP_WRITE, 0, 1'b0, 0));
		send_item(mk(bra_pkg::OP_SCAN, 0, 1'b0, 1));

		phase_bytes = '{8'd255, 8'd128, 8'd4, 8'd16, 8'd0, 8'd1, 8'd64,
			8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
		foreach (phase_bytes[p]) begin
			write_bytes_in_use(phase_bytes[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(rand_request());
				if (n == PHASE_ITEMS / 2)
					idle_until_drained();
			end
		end

		idle_until_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/bra_pkg.sv
rtl/core/bra_cell.sv
rtl/core/bra_scan.sv
rtl/core/bitmap_run_allocator_unit.sv
verif/bitmap_run_allocator_unit_tb.sv
